@@ design/ftwm_pkg.sv @@
// Shared types and constants of the frame-time window monitor.
package ftwm_pkg;

  localparam int unsigned FT_W   = 20;
  localparam int unsigned RATE_W = 22;
  localparam int unsigned ACC_W  = 21;
  localparam int unsigned HIST_W = 11;
  localparam int unsigned CIDX_W = 2;

  localparam logic [RATE_W-1:0] RATE_NUM   = 22'd4096000;
  localparam logic [7:0]        DECAY_MUL  = 8'd246;
  localparam logic [FT_W-1:0]   PERIOD_RST = 20'd46080;
  localparam logic [HIST_W-1:0] HIST_RST   = 11'd600;
  localparam logic [HIST_W-1:0] HIST_MIN   = 11'd2;

  typedef enum logic [CIDX_W-1:0] {
    REG_SHOW   = 2'd0,
    REG_PERIOD = 2'd1,
    REG_HIST   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIVM,
    ST_DIVR,
    ST_EMIT
  } state_t;

endpackage

@@ design/frame_time_window_monitor.sv @@
// Top level of the frame-time window monitor.
//
// Frame-time samples arrive on the in_ stream, one per transaction, in units
// of 1/256 ms. Each sample is written into a ring of the newest samples and
// updates the worst sample. While display is enabled, samples also feed a
// refresh accumulator; when it reaches the refresh period, one result
// transaction leaves on the out_ stream with the window mean, the frame rate
// in 1/16 fps, the worst sample and the number of samples averaged.
// A sample that causes no result does not hold the in_ stream. A sample that
// causes a result is offered on the out_ stream after the ring is read back
// one entry per cycle to form a sum of SUM_W = 20 + clog2(WINDOW + 1) bits,
// where WINDOW defaults to 96, and a bit-serial divider produces the mean and
// afterwards the rate, one quotient bit per cycle. A mean of zero skips the
// rate division. Only one sample is processed at a time. The result sits in an
// output register, so a stalled receiver holds the block only when a second
// result is ready. Reset clears all control state and sets the registers to
// their defaults; the ring contents need no clearing.
module frame_time_window_monitor
  import ftwm_pkg::*;
#(
  parameter int unsigned WINDOW = 96
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // frame_time [19:0], zero padding above.
  input  logic [23:0]                  in_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CIDX_W-1:0]            cfg_index,
  input  logic [FT_W-1:0]              cfg_data,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // mean_frame_time, frame_rate, worst_frame_time, window_count, zero padding.
  output logic [((2*FT_W+RATE_W+$clog2(WINDOW+1)+7)/8)*8-1:0] out_tdata
);

  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SW   = FT_W + CW;
  localparam int unsigned DW   = SW + 1;
  localparam int unsigned DCW  = $clog2(DW + 1);
  localparam int unsigned OTW  = ((2*FT_W + RATE_W + CW + 7) / 8) * 8;

  logic [FT_W-1:0]   ring [WINDOW];

  state_t            state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SW-1:0]     sum_r, sum_nxt;
  logic [FT_W-1:0]   worst_r, worst_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              show_r, show_nxt;
  logic [FT_W-1:0]   period_r, period_nxt;
  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     rd_left_r, rd_left_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [FT_W-1:0]   rd_data_r;
  logic [DW-1:0]     num_r, num_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [FT_W-1:0]   rem_r, rem_nxt;
  logic [FT_W-1:0]   den_r, den_nxt;
  logic [DCW-1:0]    dcnt_r, dcnt_nxt;
  logic [FT_W-1:0]   mean_r, mean_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OTW-1:0]    out_tdata_r, out_tdata_nxt;

  logic              in_fire;
  logic              rd_en;
  logic [FT_W-1:0]   sample;
  logic [HIST_W-1:0] eff_lim;
  logic [CW:0]       cnt_inc;
  logic [CW-1:0]     cnt_upd;
  logic [ACC_W-1:0]  acc_add;
  logic              emit;
  logic [FT_W:0]     trial;
  logic              ge;
  logic [FT_W-1:0]   mean_sat;
  logic [RATE_W-1:0] rate_sat;
  logic [27:0]       dec_prod;
  logic              out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign in_fire  = in_tvalid && in_tready;
  assign sample   = in_tdata[FT_W-1:0];
  assign out_free = !out_tvalid_r || out_tready;
  assign rd_en    = (state_r == ST_SUM) && (rd_left_r != '0);

  always_comb begin
    eff_lim = (hist_r < HIST_MIN) ? HIST_MIN : hist_r;
    if (eff_lim > HIST_W'(WINDOW)) begin
      eff_lim = HIST_W'(WINDOW);
    end
    cnt_inc = {1'b0, cnt_r} + (CW+1)'(1);
    cnt_upd = (cnt_inc > (CW+1)'(eff_lim)) ? eff_lim[CW-1:0] : cnt_inc[CW-1:0];
    acc_add = acc_r + ACC_W'(sample);
    emit    = show_r && (acc_add >= ACC_W'(period_r));
  end

  always_comb begin
    trial    = {rem_r, num_r[DW-1]};
    ge       = (trial >= {1'b0, den_r});
    mean_sat = (quo_r[DW-1:FT_W] != '0) ? '1 : quo_r[FT_W-1:0];
    rate_sat = (quo_r[DW-1:RATE_W] != '0) ? '1 : quo_r[RATE_W-1:0];
    dec_prod = worst_r * DECAY_MUL;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && emit) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if ((rd_left_r == '0) && !rd_pend_r) begin
          state_nxt = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (dcnt_r == '0) begin
          state_nxt = (mean_sat == '0) ? ST_EMIT : ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (dcnt_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt         = wp_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    worst_nxt      = worst_r;
    acc_nxt        = acc_r;
    show_nxt       = show_r;
    period_nxt     = period_r;
    hist_nxt       = hist_r;
    rd_ptr_nxt     = rd_ptr_r;
    rd_left_nxt    = rd_left_r;
    rd_pend_nxt    = rd_en;
    num_nxt        = num_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    dcnt_nxt       = dcnt_r;
    mean_nxt       = mean_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_SHOW:   show_nxt   = cfg_data[0];
        REG_PERIOD: period_nxt = cfg_data;
        REG_HIST:   hist_nxt   = cfg_data[HIST_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          wp_nxt      = (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + AW'(1);
          cnt_nxt     = cnt_upd;
          worst_nxt   = (sample > worst_r) ? sample : worst_r;
          rd_ptr_nxt  = wp_r;
          rd_left_nxt = cnt_upd;
          sum_nxt     = '0;
          if (show_r) begin
            acc_nxt = emit ? '0 : acc_add;
          end
        end
      end
      ST_SUM: begin
        if (rd_en) begin
          rd_ptr_nxt  = (rd_ptr_r == '0) ? AW'(WINDOW - 1) : rd_ptr_r - AW'(1);
          rd_left_nxt = rd_left_r - CW'(1);
        end
        if (rd_pend_r) begin
          sum_nxt = sum_r + SW'(rd_data_r);
        end
        if ((rd_left_r == '0) && !rd_pend_r) begin
          num_nxt  = {1'b0, sum_r};
          den_nxt  = FT_W'(cnt_r);
          rem_nxt  = '0;
          quo_nxt  = '0;
          dcnt_nxt = DCW'(DW);
        end
      end
      ST_DIVM, ST_DIVR: begin
        if (dcnt_r != '0) begin
          rem_nxt  = ge ? FT_W'(trial - {1'b0, den_r}) : trial[FT_W-1:0];
          quo_nxt  = {quo_r[DW-2:0], ge};
          num_nxt  = {num_r[DW-2:0], 1'b0};
          dcnt_nxt = dcnt_r - DCW'(1);
        end else if (state_r == ST_DIVM) begin
          mean_nxt = mean_sat;
          num_nxt  = DW'(RATE_NUM);
          den_nxt  = mean_sat;
          rem_nxt  = '0;
          quo_nxt  = '0;
          dcnt_nxt = DCW'(DW);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OTW'({cnt_r, worst_r,
                                 (mean_r == '0) ? RATE_W'(0) : rate_sat, mean_r});
          worst_nxt      = dec_prod[27:8];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ring[wp_r] <= sample;
    end
    if (rd_en) begin
      rd_data_r <= ring[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      cnt_r        <= '0;
      sum_r        <= '0;
      worst_r      <= '0;
      acc_r        <= '0;
      show_r       <= 1'b0;
      period_r     <= PERIOD_RST;
      hist_r       <= HIST_RST;
      rd_left_r    <= '0;
      rd_pend_r    <= 1'b0;
      dcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      worst_r      <= worst_nxt;
      acc_r        <= acc_nxt;
      show_r       <= show_nxt;
      period_r     <= period_nxt;
      hist_r       <= hist_nxt;
      rd_left_r    <= rd_left_nxt;
      rd_pend_r    <= rd_pend_nxt;
      dcnt_r       <= dcnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r    <= rd_ptr_nxt;
    num_r       <= num_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    mean_r      <= mean_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule
